// File: rtl/aec_pkg.sv
// Shared types and constants for the ASCII expression calculator.
package aec_pkg;

   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam int unsigned WORD_BITS = 32;

   typedef struct packed {
      logic       start;
      logic [2:0] op;
   } arith_req_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic status;
   } arith_rsp_type;

endpackage

// File: rtl/aec_parse.sv
// Text parser that builds the two operands and the operator from incoming bytes.
module aec_parse import aec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            char_code,
   input  logic                  last_byte,
   output logic [WORD_BITS-1:0]  left_operand,
   output logic [WORD_BITS-1:0]  right_operand,
   output logic [2:0]            op_code
);

   logic [WORD_BITS-1:0] left_ff, left_in;
   logic [WORD_BITS-1:0] right_ff, right_in;
   logic [2:0]           op_ff, op_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 neg_ff, neg_in;
   logic                 seen_ff, seen_in;
   logic                 spaces_ff, spaces_in;
   logic                 abort_ff, abort_in;

   logic                 is_digit;
   logic [7:0]           digit;
   logic [WORD_BITS-1:0] signed_acc;
   logic [2:0]           code;

   assign is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign digit      = char_code - CHAR_ZERO;
   assign signed_acc = neg_ff ? ({WORD_BITS{1'b0}} - acc_ff) : acc_ff;

   always_comb begin
      case (char_code)
         CHAR_PLUS:  code = OP_ADD;
         CHAR_MINUS: code = OP_SUB;
         CHAR_STAR:  code = OP_MUL;
         CHAR_SLASH: code = OP_DIV;
         default:    code = OP_NONE;
      endcase
   end

   always_comb begin
      left_in   = left_ff;
      right_in  = right_ff;
      op_in     = op_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      seen_in   = seen_ff;
      spaces_in = spaces_ff;
      abort_in  = abort_ff;
      if (byte_valid) begin
         if (last_byte) begin
            if (!abort_ff) begin
               right_in = signed_acc;
            end
            acc_in    = '0;
            neg_in    = 1'b0;
            seen_in   = 1'b0;
            spaces_in = 1'b1;
            abort_in  = 1'b0;
         end else if (!abort_ff) begin
            if (is_digit) begin
               // The multiply by ten is two shifts and an add.
               acc_in    = (acc_ff << 3) + (acc_ff << 1)
                           + {{(WORD_BITS-8){1'b0}}, digit};
               spaces_in = 1'b0;
            end else if (char_code == CHAR_SPACE) begin
               acc_in = acc_ff;
            end else if (code == OP_NONE) begin
               abort_in = 1'b1;
            end else if (code == OP_SUB && spaces_ff) begin
               neg_in    = 1'b1;
               spaces_in = 1'b0;
            end else if (seen_ff) begin
               abort_in = 1'b1;
            end else begin
               op_in     = code;
               seen_in   = 1'b1;
               left_in   = signed_acc;
               acc_in    = '0;
               neg_in    = 1'b0;
               spaces_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= '0;
         op_ff     <= OP_NONE;
         acc_ff    <= '0;
         neg_ff    <= 1'b0;
         seen_ff   <= 1'b0;
         spaces_ff <= 1'b1;
         abort_ff  <= 1'b0;
      end else begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         op_ff     <= op_in;
         acc_ff    <= acc_in;
         neg_ff    <= neg_in;
         seen_ff   <= seen_in;
         spaces_ff <= spaces_in;
         abort_ff  <= abort_in;
      end
   end

   assign left_operand  = left_ff;
   assign right_operand = right_ff;
   assign op_code       = op_ff;

endmodule

// File: rtl/aec_arith.sv
// Iterative arithmetic unit with one shared adder for add, subtract, multiply and divide.
module aec_arith import aec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  arith_req_type         req,
   input  logic [WORD_BITS-1:0]  left_operand,
   input  logic [WORD_BITS-1:0]  right_operand,
   input  logic                  ack,
   output arith_rsp_type         rsp,
   output logic [WORD_BITS-1:0]  value
);

   localparam int unsigned CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [2:0]           op_ff, op_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] x_ff, x_in;
   logic [WORD_BITS-1:0] y_ff, y_in;
   logic                 neg_ff, neg_in;
   logic                 status_ff, status_in;

   logic [WORD_BITS:0]   add_a, add_b;
   logic                 add_sub;
   logic [WORD_BITS+1:0] sum;
   logic [WORD_BITS-1:0] left_mag, right_mag;

   assign left_mag  = left_operand[WORD_BITS-1]
                      ? ({WORD_BITS{1'b0}} - left_operand) : left_operand;
   assign right_mag = right_operand[WORD_BITS-1]
                      ? ({WORD_BITS{1'b0}} - right_operand) : right_operand;

   always_comb begin
      add_a   = {1'b0, left_operand};
      add_b   = {1'b0, right_operand};
      add_sub = (req.op == OP_SUB);
      if (state_ff == ST_RUN) begin
         add_b = {1'b0, x_ff};
         if (op_ff == OP_MUL) begin
            add_a   = {1'b0, acc_ff};
            add_sub = 1'b0;
         end else begin
            add_a   = {acc_ff, y_ff[WORD_BITS-1]};
            add_sub = 1'b1;
         end
      end
   end

   assign sum = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b}
                + {{(WORD_BITS+1){1'b0}}, add_sub};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      neg_in    = neg_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.start) begin
               op_in     = req.op;
               cnt_in    = '0;
               status_in = 1'b0;
               neg_in    = 1'b0;
               y_in      = '0;
               case (req.op)
                  OP_ADD, OP_SUB: begin
                     acc_in   = sum[WORD_BITS-1:0];
                     state_in = ST_DONE;
                  end
                  OP_MUL: begin
                     acc_in   = '0;
                     x_in     = left_operand;
                     y_in     = right_operand;
                     state_in = ST_RUN;
                  end
                  OP_DIV: begin
                     acc_in = '0;
                     if (right_operand == '0) begin
                        status_in = 1'b1;
                        state_in  = ST_DONE;
                     end else begin
                        x_in     = right_mag;
                        y_in     = left_mag;
                        neg_in   = left_operand[WORD_BITS-1] ^ right_operand[WORD_BITS-1];
                        state_in = ST_RUN;
                     end
                  end
                  default: begin
                     op_in    = OP_NONE;
                     acc_in   = '0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (op_ff == OP_MUL) begin
               if (y_ff[0]) begin
                  acc_in = sum[WORD_BITS-1:0];
               end
               x_in = x_ff << 1;
               y_in = y_ff >> 1;
            end else begin
               // Restoring division step: keep the difference when no borrow occurs.
               if (sum[WORD_BITS+1]) begin
                  acc_in = sum[WORD_BITS-1:0];
               end else begin
                  acc_in = add_a[WORD_BITS-1:0];
               end
               y_in = {y_ff[WORD_BITS-2:0], sum[WORD_BITS+1]};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         op_ff     <= OP_NONE;
         status_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         op_ff     <= op_in;
         status_ff <= status_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      neg_ff <= neg_in;
   end

   assign rsp.idle   = (state_ff == ST_IDLE);
   assign rsp.done   = (state_ff == ST_DONE);
   assign rsp.status = status_ff;
   assign value = (op_ff == OP_DIV)
                  ? (neg_ff ? ({WORD_BITS{1'b0}} - y_ff) : y_ff)
                  : acc_ff;

   assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == ST_IDLE)
      else $error("Operation started while the unit was busy.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cnt_ff != CNT_LAST) |=> state_ff == ST_RUN)
      else $error("Iteration ended early.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !ack) |=> state_ff == ST_DONE)
      else $error("Result dropped before it was taken.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status_ff) |-> op_ff == OP_DIV)
      else $error("Error status set for an operation other than divide.");

endmodule

// File: rtl/ascii_expression_calculator.sv
// Top level of the ASCII expression calculator with stream handshakes and result register.
// A text byte (req_tuser low) is taken whenever the arithmetic unit is idle; an item with
// req_tuser high starts the operation. Add, subtract, no operator and divide by zero go
// straight to the DONE state, multiply and divide after the 32 iterations of the shared adder;
// the result then loads into the output register. A full output register delays the load, and
// no item is taken until the cycle after it. Synchronous active-high reset clears the parser.
module ascii_expression_calculator import aec_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,  // char_code
   input  logic                 req_tlast,  // last_byte
   input  logic                 req_tuser,  // mode
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [WORD_BITS-1:0] rsp_tdata,  // value
   output logic                 rsp_tuser   // status
);

   logic [WORD_BITS-1:0] left_operand;
   logic [WORD_BITS-1:0] right_operand;
   logic [2:0]           op_code;
   logic                 req_fire;
   logic                 ack;
   arith_req_type        arith_req;
   arith_rsp_type        arith_rsp;
   logic [WORD_BITS-1:0] arith_value;

   logic                 out_valid_ff, out_valid_in;
   logic [WORD_BITS-1:0] out_value_ff, out_value_in;
   logic                 out_status_ff, out_status_in;

   assign req_tready = arith_rsp.idle;
   assign req_fire   = req_tvalid && req_tready;

   assign arith_req.start = req_fire && req_tuser;
   assign arith_req.op    = op_code;

   aec_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .byte_valid    (req_fire && !req_tuser),
      .char_code     (req_tdata),
      .last_byte     (req_tlast),
      .left_operand  (left_operand),
      .right_operand (right_operand),
      .op_code       (op_code)
   );

   aec_arith u_arith (
      .clock         (clock),
      .reset         (reset),
      .req           (arith_req),
      .left_operand  (left_operand),
      .right_operand (right_operand),
      .ack           (ack),
      .rsp           (arith_rsp),
      .value         (arith_value)
   );

   assign ack = arith_rsp.done && (!out_valid_ff || rsp_tready);

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (ack) begin
         out_valid_in  = 1'b1;
         out_value_in  = arith_value;
         out_status_in = arith_rsp.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_status_ff;

endmodule
